[rtl/rpc_pkg.sv]
// shared types, constants and helper functions of the rectangular/polar converter
package rpc_pkg;

  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int GUARD     = 8;
  localparam int ANG_FRAC  = 24;
  // datapath width: data plus guard bits plus headroom for cordic growth
  localparam int CW        = DATA_W + GUARD + 2;
  // angle width: degrees in q.24, up to about +/-280 degrees mid-flight
  localparam int AW        = 34;

  localparam int ITER_DEF  = 16;
  localparam int ITER_MIN  = 8;
  localparam int ITER_MAX  = 30;

  localparam logic [KIND_W-1:0] KIND_RECT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POLAR = 2'd1;

  typedef enum logic [1:0] {
    OP_VEC,
    OP_ROT,
    OP_BAD
  } op_e;

  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1509949440;
  localparam logic signed [AW-1:0] HALF_TURN    = 34'sd3019898880;
  localparam logic signed [AW-1:0] THREE_QUARTER = 34'sd4529848320;
  localparam logic signed [AW-1:0] FULL_TURN    = 34'sd6039797760;

  // angle reduction modulo 360 degrees on the integer part of the input
  localparam logic [16:0] RED_OFS    = 17'd33120;  // 92 * 360
  localparam logic [16:0] RED_RECIP  = 17'd93207;  // ceil(2^25 / 360)
  localparam int          RED_SHIFT  = 25;
  localparam logic [16:0] RED_MOD    = 17'd360;
  localparam int          RED_Q_W    = 9;
  localparam int          RED_R_W    = 9;

  // atan(2^-i) in degrees, q.24
  localparam logic [29:0] ATAN_TAB [ITER_MAX] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
    30'd29,        30'd14,        30'd7,         30'd4,         30'd2
  };

  typedef struct packed {
    op_e                      op;
    logic                     zero;
    logic                     flip;
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] second;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
  } cord_t;

  function automatic int clamp_iter(int n);
    int r;
    r = n;
    if (r < ITER_MIN) r = ITER_MIN;
    if (r > ITER_MAX) r = ITER_MAX;
    return r;
  endfunction

  // cordic gain compensation, q0.32
  function automatic logic [31:0] gain_of(int n);
    logic [31:0] k;
    case (n)
      8:       k = 32'd2608158028;
      9:       k = 32'd2608138129;
      10:      k = 32'd2608133154;
      11:      k = 32'd2608131911;
      12:      k = 32'd2608131600;
      13:      k = 32'd2608131522;
      14:      k = 32'd2608131503;
      15:      k = 32'd2608131498;
      16:      k = 32'd2608131497;
      default: k = 32'd2608131496;
    endcase
    return k;
  endfunction

endpackage

[rtl/rpc_in_if.sv]
// input channel of the converter: vector transaction with kind selector
interface rpc_in_if;
  import rpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] first_value;
  logic signed [DATA_W-1:0] second_value;

  modport source (output valid, kind, first_value, second_value, input ready);
  modport sink   (input valid, kind, first_value, second_value, output ready);
endinterface

[rtl/rpc_out_if.sv]
// output channel of the converter: rectangular and polar result transaction
interface rpc_out_if;
  import rpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_coord;
  logic signed [DATA_W-1:0] y_coord;
  logic signed [DATA_W-1:0] magnitude;
  logic signed [DATA_W-1:0] angle_deg;
  logic                     bad_kind;

  modport source (output valid, x_coord, y_coord, magnitude, angle_deg, bad_kind,
                  input ready);
  modport sink   (input valid, x_coord, y_coord, magnitude, angle_deg, bad_kind,
                  output ready);
endinterface

[rtl/rpc_pre.sv]
// two front-end stages: decode, pre-rotation, angle reduction and gain scaling
module rpc_pre #(
  parameter int ITERATIONS = rpc_pkg::ITER_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [rpc_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [rpc_pkg::DATA_W-1:0] first_i,
  input  logic signed [rpc_pkg::DATA_W-1:0] second_i,
  output logic                             valid_o,
  output rpc_pkg::cord_t                   data_o
);
  import rpc_pkg::*;

  localparam logic [31:0] K = gain_of(clamp_iter(ITERATIONS));

  // stage 1
  side_t                side_d, s1_side_q;
  logic signed [CW-1:0] x_d, y_d, s1_x_q, s1_y_q;
  logic signed [AW-1:0] z_d, s1_z_q;
  logic signed [63:0]   mk_d, s1_mk_q;
  logic [RED_Q_W-1:0]   q_d, s1_q_q;
  logic                 s1_valid_q;
  logic signed [CW-1:0] xa, ya;
  logic signed [63:0]   a64, k64;
  logic [16:0]          u1;
  logic [33:0]          qp;

  // stage 2
  cord_t                cord_d, data_q;
  logic                 valid_q;
  logic [16:0]          u2, rem17;
  logic signed [AW-1:0] r0, r_red;
  logic                 flip;
  logic signed [63:0]   mk_rnd;
  logic signed [CW-1:0] x_rot;

  always_comb begin
    side_d        = '0;
    side_d.first  = first_i;
    side_d.second = second_i;
    side_d.zero   = (first_i == '0) && (second_i == '0);
    case (kind_i)
      KIND_RECT:  side_d.op = OP_VEC;
      KIND_POLAR: side_d.op = OP_ROT;
      default:    side_d.op = OP_BAD;
    endcase

    xa = CW'(first_i) <<< GUARD;
    ya = CW'(second_i) <<< GUARD;
    if (first_i[DATA_W-1]) begin
      x_d = -xa;
      y_d = -ya;
      z_d = second_i[DATA_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      x_d = xa;
      y_d = ya;
      z_d = '0;
    end

    a64  = 64'(first_i);
    k64  = $signed(64'(K));
    mk_d = a64 * k64;

    u1  = 17'({second_i[DATA_W-1], second_i[DATA_W-1:16]}) + RED_OFS;
    qp  = 34'(u1) * 34'(RED_RECIP);
    q_d = qp[RED_SHIFT +: RED_Q_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= side_d;
      s1_x_q    <= x_d;
      s1_y_q    <= y_d;
      s1_z_q    <= z_d;
      s1_mk_q   <= mk_d;
      s1_q_q    <= q_d;
    end
  end

  always_comb begin
    u2    = 17'({s1_side_q.second[DATA_W-1], s1_side_q.second[DATA_W-1:16]}) + RED_OFS;
    rem17 = u2 - 17'(s1_q_q) * RED_MOD;
    r0    = AW'({rem17[RED_R_W-1:0], s1_side_q.second[15:0], {GUARD{1'b0}}});

    // fold into [-90, 90], remembering a half-turn
    if (r0 <= QUARTER_TURN) begin
      r_red = r0;
      flip  = 1'b0;
    end else if (r0 < THREE_QUARTER) begin
      r_red = r0 - HALF_TURN;
      flip  = 1'b1;
    end else begin
      r_red = r0 - FULL_TURN;
      flip  = 1'b0;
    end

    mk_rnd = s1_mk_q + 64'sd8388608;
    x_rot  = CW'($signed(mk_rnd[63:DATA_W-GUARD]));

    cord_d      = '0;
    cord_d.side = s1_side_q;
    if (s1_side_q.op == OP_ROT) begin
      cord_d.x         = x_rot;
      cord_d.y         = '0;
      cord_d.z         = r_red;
      cord_d.side.flip = flip;
    end else begin
      cord_d.x = s1_x_q;
      cord_d.y = s1_y_q;
      cord_d.z = s1_z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= cord_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/rpc_cell.sv]
// one cordic micro-rotation, shared by vectoring and rotation modes
module rpc_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rpc_pkg::cord_t data_i,
  output logic           valid_o,
  output rpc_pkg::cord_t data_o
);
  import rpc_pkg::*;

  localparam logic signed [AW-1:0] ATAN = AW'(ATAN_TAB[SHIFT]);

  logic signed [CW-1:0] x_in, y_in, dx, dy;
  logic signed [AW-1:0] z_in;
  logic                 plus;
  cord_t                cord_d, data_q;
  logic                 valid_q;

  always_comb begin
    x_in = data_i.x;
    y_in = data_i.y;
    z_in = data_i.z;
    dx   = y_in >>> SHIFT;
    dy   = x_in >>> SHIFT;
    // vectoring drives y to zero, rotation drives z to zero
    plus = (data_i.side.op == OP_VEC) ? !y_in[CW-1] : z_in[AW-1];

    cord_d      = data_i;
    if (plus) begin
      cord_d.x = x_in + dx;
      cord_d.y = y_in - dy;
      cord_d.z = z_in + ATAN;
    end else begin
      cord_d.x = x_in - dx;
      cord_d.y = y_in + dy;
      cord_d.z = z_in - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= cord_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/rpc_post.sv]
// back-end stages: gain multiply, angle clamp, rounding, saturation and output register
module rpc_post #(
  parameter int ITERATIONS = rpc_pkg::ITER_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  rpc_pkg::cord_t                    data_i,
  output logic                              valid_o,
  output logic signed [rpc_pkg::DATA_W-1:0] x_coord_o,
  output logic signed [rpc_pkg::DATA_W-1:0] y_coord_o,
  output logic signed [rpc_pkg::DATA_W-1:0] magnitude_o,
  output logic signed [rpc_pkg::DATA_W-1:0] angle_deg_o,
  output logic                              bad_kind_o
);
  import rpc_pkg::*;

  localparam logic [31:0] K    = gain_of(clamp_iter(ITERATIONS));
  localparam int          M_W  = CW - 1;
  localparam int          HI_W = M_W - 32;
  localparam int          PH_W = HI_W + 32;
  localparam int          XS_W = CW - GUARD;
  localparam logic signed [XS_W-1:0] SAT_MAX = XS_W'(64'sd2147483647);
  localparam logic signed [XS_W-1:0] SAT_MIN = XS_W'(-64'sd2147483648);

  // stage 1
  logic signed [CW-1:0] x_in, y_in, xf_d, yf_d, q1_xf_q, q1_yf_q;
  logic signed [AW-1:0] z_in, zc_d, q1_zc_q;
  logic [M_W-1:0]       m;
  logic [63:0]          plo_d, q1_plo_q;
  logic [PH_W-1:0]      phi_d, q1_phi_q;
  side_t                q1_side_q;
  logic                 q1_valid_q;

  // output stage
  logic [PH_W:0]            msum;
  logic [PH_W-GUARD:0]      msh;
  logic [DATA_W-1:0]        mag_sat;
  logic signed [AW-1:0]     zr;
  logic signed [CW-1:0]     xr, yr;
  logic signed [DATA_W-1:0] x_d, y_d, mag_d, ang_d;
  logic                     bad_d;
  logic signed [DATA_W-1:0] x_q, y_q, mag_q, ang_q;
  logic                     bad_q, valid_q;

  function automatic logic signed [DATA_W-1:0] sat_data(logic signed [XS_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    x_in = data_i.x;
    y_in = data_i.y;
    z_in = data_i.z;

    m     = (x_in > 0) ? x_in[M_W-1:0] : '0;
    plo_d = 64'(m[31:0]) * 64'(K);
    phi_d = PH_W'(m[M_W-1:32]) * PH_W'(K);

    if (z_in > HALF_TURN) begin
      zc_d = HALF_TURN;
    end else if (z_in < -HALF_TURN) begin
      zc_d = -HALF_TURN;
    end else begin
      zc_d = z_in;
    end

    xf_d = data_i.side.flip ? -x_in : x_in;
    yf_d = data_i.side.flip ? -y_in : y_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_valid_q <= 1'b0;
    end else if (en_i) begin
      q1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_side_q <= data_i.side;
      q1_xf_q   <= xf_d;
      q1_yf_q   <= yf_d;
      q1_zc_q   <= zc_d;
      q1_plo_q  <= plo_d;
      q1_phi_q  <= phi_d;
    end
  end

  always_comb begin
    msum    = (PH_W+1)'(q1_phi_q) + (PH_W+1)'(q1_plo_q[63:32]) + (PH_W+1)'(128);
    msh     = msum[PH_W:GUARD];
    mag_sat = (msh > (PH_W-GUARD+1)'(32'h7fff_ffff)) ? 32'h7fff_ffff : msh[DATA_W-1:0];

    zr = q1_zc_q + AW'(128);
    xr = q1_xf_q + CW'(128);
    yr = q1_yf_q + CW'(128);

    x_d   = '0;
    y_d   = '0;
    mag_d = '0;
    ang_d = '0;
    bad_d = 1'b0;
    case (q1_side_q.op)
      OP_VEC: begin
        x_d = q1_side_q.first;
        y_d = q1_side_q.second;
        if (!q1_side_q.zero) begin
          mag_d = $signed(mag_sat);
          ang_d = DATA_W'($signed(zr[AW-1:GUARD]));
        end
      end
      OP_ROT: begin
        x_d   = sat_data($signed(xr[CW-1:GUARD]));
        y_d   = sat_data($signed(yr[CW-1:GUARD]));
        mag_d = q1_side_q.first;
        ang_d = q1_side_q.second;
      end
      default: begin
        bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= q1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      mag_q <= mag_d;
      ang_q <= ang_d;
      bad_q <= bad_d;
    end
  end

  assign valid_o     = valid_q;
  assign x_coord_o   = x_q;
  assign y_coord_o   = y_q;
  assign magnitude_o = mag_q;
  assign angle_deg_o = ang_q;
  assign bad_kind_o  = bad_q;

endmodule

[rtl/rect_polar_converter.sv]
// top level of the pipelined cordic rectangular/polar converter
//
// converts one vector per transaction: kind 0 takes (x, y) and returns the
// magnitude and the four-quadrant angle in degrees, kind 1 takes (magnitude,
// angle in degrees) and returns x and y; kinds 2 and 3 return all zeros with
// bad_kind set. all values are signed q16.16. the block is a linear pipeline
// of two front-end stages (decode, pre-rotation, modulo-360 reduction, gain
// scaling), a row of cordic cells, one per iteration with ITERATIONS clamped
// to 8..30 (one micro-rotation each, shift set by position) and two back-end
// stages (gain multiply, rounding, saturation, output register). one
// transaction is accepted every cycle while the output is not stalled. the
// whole pipeline advances together: it moves whenever the output register is
// empty or its transaction is being taken, so in ready follows the output
// side within the same cycle.
module rect_polar_converter #(
  parameter int ITERATIONS = rpc_pkg::ITER_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpc_in_if.sink    in_i,
  rpc_out_if.source out_o
);
  import rpc_pkg::*;

  localparam int N = clamp_iter(ITERATIONS);

  // global advance for every stage
  logic  en;
  logic  out_valid;

  // chain of cells, entry 0 fed by the front end
  cord_t        chain_data  [N+1];
  logic [N:0]   chain_valid;

  assign en         = !out_valid || out_o.ready;
  assign in_i.ready = en;

  rpc_pre #(
    .ITERATIONS (ITERATIONS)
  ) u_pre (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .kind_i   (in_i.kind),
    .first_i  (in_i.first_value),
    .second_i (in_i.second_value),
    .valid_o  (chain_valid[0]),
    .data_o   (chain_data[0])
  );

  // one cell per micro-rotation, shift and atan fixed by position
  for (genvar g = 0; g < N; g++) begin : g_cell
    rpc_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  rpc_post #(
    .ITERATIONS (ITERATIONS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (chain_valid[N]),
    .data_i      (chain_data[N]),
    .valid_o     (out_valid),
    .x_coord_o   (out_o.x_coord),
    .y_coord_o   (out_o.y_coord),
    .magnitude_o (out_o.magnitude),
    .angle_deg_o (out_o.angle_deg),
    .bad_kind_o  (out_o.bad_kind)
  );

  assign out_o.valid = out_valid;

endmodule

[rtl/rpc_checker.sv]
// port-level checks of the converter, bound to the top level
module rpc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [rpc_pkg::DATA_W-1:0] x_coord_i,
  input logic signed [rpc_pkg::DATA_W-1:0] y_coord_i,
  input logic signed [rpc_pkg::DATA_W-1:0] magnitude_i,
  input logic signed [rpc_pkg::DATA_W-1:0] angle_deg_i,
  input logic                              bad_kind_i
);

  // input back-pressure only comes from a held output transaction
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a held output transaction");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped before the transaction was taken");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(x_coord_i) && $stable(y_coord_i) &&
      $stable(magnitude_i) && $stable(angle_deg_i) && $stable(bad_kind_i)))
    else $error("stalled output transaction changed");

  // an invalid kind clears every numeric field
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && bad_kind_i) |-> (x_coord_i == '0 && y_coord_i == '0 &&
      magnitude_i == '0 && angle_deg_i == '0))
    else $error("bad kind transaction with non-zero fields");

endmodule

bind rect_polar_converter rpc_checker u_rpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .x_coord_i   (out_o.x_coord),
  .y_coord_i   (out_o.y_coord),
  .magnitude_i (out_o.magnitude),
  .angle_deg_i (out_o.angle_deg),
  .bad_kind_i  (out_o.bad_kind)
);
